FILE: hw/rtl/ihpc_pkg.sv
// Package for the IPv4 header parse and check unit.
// Holds byte offsets, protocol numbers, class codes and the packed result word.
// No dependencies.
package ihpc_pkg;

    localparam int unsigned MAX_PACKET_BYTES_DEF = 65535;

    localparam int unsigned CNT_W     = 16;
    localparam int unsigned TDATA_O_W = 88;

    // Minimum legal header size in bytes
    localparam logic [5:0] MIN_HDR_BYTES = 6'd20;

    // Byte offsets of captured header fields
    localparam logic [15:0] OFS_VER_IHL  = 16'd0;
    localparam logic [15:0] OFS_TLEN_HI  = 16'd2;
    localparam logic [15:0] OFS_TLEN_LO  = 16'd3;
    localparam logic [15:0] OFS_FRAG_HI  = 16'd6;
    localparam logic [15:0] OFS_FRAG_LO  = 16'd7;
    localparam logic [15:0] OFS_TTL      = 16'd8;
    localparam logic [15:0] OFS_PROTO    = 16'd9;
    localparam logic [15:0] OFS_CSUM_HI  = 16'd10;
    localparam logic [15:0] OFS_CSUM_LO  = 16'd11;

    // Protocol numbers
    localparam logic [7:0] PNUM_ICMP = 8'd1;
    localparam logic [7:0] PNUM_IPIP = 8'd4;
    localparam logic [7:0] PNUM_TCP  = 8'd6;
    localparam logic [7:0] PNUM_UDP  = 8'd17;
    localparam logic [7:0] PNUM_IPV6 = 8'd41;

    // Next-protocol class codes
    localparam logic [2:0] CLS_PAYLOAD = 3'd0;
    localparam logic [2:0] CLS_TCP     = 3'd1;
    localparam logic [2:0] CLS_UDP     = 3'd2;
    localparam logic [2:0] CLS_ICMP    = 3'd3;
    localparam logic [2:0] CLS_IPIP    = 3'd4;
    localparam logic [2:0] CLS_IPV6    = 3'd5;
    localparam logic [2:0] CLS_NONE    = 3'd6;

    // Result word; last member sits in the lowest bits
    typedef struct packed {
        logic [2:0]  pad;
        logic [12:0] frag_offset;
        logic [2:0]  flags;
        logic [7:0]  ttl;
        logic [2:0]  next_class;
        logic [7:0]  protocol;
        logic [15:0] kept_size;
        logic [15:0] total_length;
        logic [5:0]  options_bytes;
        logic [5:0]  header_bytes;
        logic [3:0]  version;
        logic        header_ok;
        logic        checksum_good;
    } t_result;

    function automatic logic [2:0] proto_class(input logic [7:0] proto);
        logic [2:0] cls;
        unique case (proto)
            PNUM_TCP:  cls = CLS_TCP;
            PNUM_UDP:  cls = CLS_UDP;
            PNUM_ICMP: cls = CLS_ICMP;
            PNUM_IPIP: cls = CLS_IPIP;
            PNUM_IPV6: cls = CLS_IPV6;
            default:   cls = CLS_PAYLOAD;
        endcase
        return cls;
    endfunction

    // 16-bit ones-complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

FILE: hw/rtl/ipv4_header_parse_check_unit.sv
// IPv4 header parser with header checksum check: top level.
// Uses ihpc_pkg; one byte in per word, one result word per packet.
//
// Takes one byte per cycle, back to back, unless stalled, through an input
// register and a per-byte update stage; the result of a packet is loaded
// into the output register on the cycle its last byte (tlast) is processed
// from the input register. Input is stalled only while a finished result
// waits in the output register and another last byte is due. The
// ones-complement sum spans the header (at least 20 bytes) with the checksum
// word taken as zero; checksum_good reads 1 while checking is disabled. The
// byte count saturates at MAX_PACKET_BYTES; bytes past it are neither
// captured nor summed. No reset sweep is needed.
module ipv4_header_parse_check_unit #(
    parameter int unsigned MAX_PACKET_BYTES = ihpc_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: bit 0 check_enable
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    // tdata: data_byte[7:0]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    // tdata: checksum_good[0], header_ok[1], version[5:2], header_bytes[11:6],
    // options_bytes[17:12], total_length[33:18], kept_size[49:34],
    // protocol[57:50], next_class[60:58], ttl[68:61], flags[71:69],
    // frag_offset[84:72], zero[87:85]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [ihpc_pkg::TDATA_O_W-1:0] m_axis_tdata
);

    localparam logic [15:0] CAP = 16'(MAX_PACKET_BYTES);

    logic        r_check_en;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eop;

    logic [15:0] r_count, n_count;
    logic [7:0]  r_ver_ihl, n_ver_ihl;
    logic [15:0] r_tlen, n_tlen;
    logic [15:0] r_frag, n_frag;
    logic [7:0]  r_ttl, n_ttl;
    logic [7:0]  r_proto, n_proto;
    logic [15:0] r_stored, n_stored;
    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_high, n_high;

    logic             r_out_valid;
    ihpc_pkg::t_result r_out, n_out;

    logic        w_proc;
    logic        w_live;
    logic        w_summed;
    logic        w_even;
    logic        w_pad;
    logic [5:0]  w_hb_cur;
    logic [5:0]  w_span;
    logic [7:0]  w_v;
    logic [15:0] w_word;
    logic [15:0] w_sum_new;
    logic [15:0] w_final;
    logic [15:0] w_cnt_m1;
    logic [5:0]  w_hb;
    logic        w_ok;

    assign o_cfg_ready   = 1'b1;
    assign w_proc        = r_in_valid && (!r_in_eop || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_proc;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // per-byte capture and checksum accumulate
    always_comb begin
        n_count  = r_count;
        n_ver_ihl = r_ver_ihl;
        n_tlen   = r_tlen;
        n_frag   = r_frag;
        n_ttl    = r_ttl;
        n_proto  = r_proto;
        n_stored = r_stored;
        n_sum    = r_sum;
        n_high   = r_high;

        w_live   = r_count < CAP;
        w_hb_cur = {r_ver_ihl[3:0], 2'b00};
        w_span   = (w_hb_cur < ihpc_pkg::MIN_HDR_BYTES) ? ihpc_pkg::MIN_HDR_BYTES : w_hb_cur;
        w_summed = w_live && (r_count < {10'd0, w_span});
        w_even   = !r_count[0];
        // checksum word counts as zero
        w_v      = (r_count == ihpc_pkg::OFS_CSUM_HI || r_count == ihpc_pkg::OFS_CSUM_LO)
                   ? 8'h00 : r_in_byte;

        if (w_live) begin
            n_count = r_count + 16'd1;
            case (r_count)
                ihpc_pkg::OFS_VER_IHL: n_ver_ihl = r_in_byte;
                ihpc_pkg::OFS_TLEN_HI: n_tlen    = {r_in_byte, r_tlen[7:0]};
                ihpc_pkg::OFS_TLEN_LO: n_tlen    = {r_tlen[15:8], r_in_byte};
                ihpc_pkg::OFS_FRAG_HI: n_frag    = {r_in_byte, r_frag[7:0]};
                ihpc_pkg::OFS_FRAG_LO: n_frag    = {r_frag[15:8], r_in_byte};
                ihpc_pkg::OFS_TTL:     n_ttl     = r_in_byte;
                ihpc_pkg::OFS_PROTO:   n_proto   = r_in_byte;
                ihpc_pkg::OFS_CSUM_HI: n_stored  = {r_in_byte, r_stored[7:0]};
                ihpc_pkg::OFS_CSUM_LO: n_stored  = {r_stored[15:8], r_in_byte};
                default: ;
            endcase
        end

        // an unpaired trailing byte is padded with a zero low byte
        w_cnt_m1 = n_count - 16'd1;
        w_pad    = n_count[0] && (w_cnt_m1 < {10'd0, w_span});
        if (w_summed) begin
            w_word = w_even ? {w_v, 8'h00} : {r_high, w_v};
        end else begin
            w_word = {r_high, 8'h00};
        end
        w_sum_new = ihpc_pkg::oc_add(r_sum, w_word);

        if (w_summed) begin
            if (w_even) begin
                n_high = w_v;
            end else begin
                n_sum = w_sum_new;
            end
        end
        w_final = ((w_summed && !w_even) || w_pad) ? w_sum_new : r_sum;
    end

    // result of the packet ending with this byte
    always_comb begin
        w_hb = {n_ver_ihl[3:0], 2'b00};
        w_ok = (n_count >= {10'd0, ihpc_pkg::MIN_HDR_BYTES})
               && (w_hb >= ihpc_pkg::MIN_HDR_BYTES)
               && ({10'd0, w_hb} <= n_tlen);

        n_out               = '0;
        n_out.checksum_good = !r_check_en || ((~w_final) == n_stored);
        n_out.header_ok     = w_ok;
        n_out.version       = n_ver_ihl[7:4];
        n_out.header_bytes  = w_hb;
        n_out.options_bytes = (w_ok && n_count >= {10'd0, w_hb})
                              ? w_hb - ihpc_pkg::MIN_HDR_BYTES : 6'd0;
        n_out.total_length  = n_tlen;
        n_out.kept_size     = (w_ok && n_count > n_tlen) ? n_tlen : n_count;
        n_out.protocol      = n_proto;
        n_out.next_class    = w_ok ? ihpc_pkg::proto_class(n_proto) : ihpc_pkg::CLS_NONE;
        n_out.ttl           = n_ttl;
        n_out.flags         = n_frag[15:13];
        n_out.frag_offset   = n_frag[12:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_en  <= 1'b1;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_ver_ihl   <= '0;
            r_tlen      <= '0;
            r_frag      <= '0;
            r_ttl       <= '0;
            r_proto     <= '0;
            r_stored    <= '0;
            r_sum       <= '0;
            r_high      <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_check_en <= i_cfg_data;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_proc && r_in_eop) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_proc) begin
                if (r_in_eop) begin
                    // clear per-packet state for the next packet
                    r_count   <= '0;
                    r_ver_ihl <= '0;
                    r_tlen    <= '0;
                    r_frag    <= '0;
                    r_ttl     <= '0;
                    r_proto   <= '0;
                    r_stored  <= '0;
                    r_sum     <= '0;
                    r_high    <= '0;
                end else begin
                    r_count   <= n_count;
                    r_ver_ihl <= n_ver_ihl;
                    r_tlen    <= n_tlen;
                    r_frag    <= n_frag;
                    r_ttl     <= n_ttl;
                    r_proto   <= n_proto;
                    r_stored  <= n_stored;
                    r_sum     <= n_sum;
                    r_high    <= n_high;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_eop  <= s_axis_tlast;
        end
        if (w_proc && r_in_eop) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: hw/rtl/ihpc_checker.sv
// Port-level checker for the IPv4 header parse and check unit.
// Uses ihpc_pkg; bound to ipv4_header_parse_check_unit below.
module ihpc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [ihpc_pkg::TDATA_O_W-1:0] m_axis_tdata
);

    ihpc_pkg::t_result w_res;
    assign w_res = m_axis_tdata;

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_bad_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !w_res.header_ok |->
            w_res.next_class == ihpc_pkg::CLS_NONE && w_res.options_bytes == 6'd0)
        else $error("bad header without class none and zero options");

    a_good_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_res.header_ok |->
            w_res.header_bytes >= ihpc_pkg::MIN_HDR_BYTES
            && {10'd0, w_res.header_bytes} <= w_res.total_length
            && w_res.kept_size <= w_res.total_length
            && w_res.next_class != ihpc_pkg::CLS_NONE)
        else $error("sane header with inconsistent lengths or class");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind ipv4_header_parse_check_unit ihpc_checker u_ihpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: test/ihpc_result_checker.sv
// Result checker for the IPv4 header parse and check unit testbench.
// Watches the config, byte and result channels, predicts each result word and compares it.
// Depends on ihpc_pkg for offsets, protocol numbers, class codes and t_result.
module ihpc_result_checker
    import ihpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic                 i_cfg_data,
    input  logic                 i_byte_valid,
    input  logic                 i_byte_ready,
    input  logic [7:0]           i_byte,
    input  logic                 i_byte_last,
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    input  logic [TDATA_O_W-1:0] i_res_word,
    output int                   o_pending,
    output int                   o_fail_count
);

    localparam int HDR_MIN = MIN_HDR_BYTES;

    // Model copy of the per-packet state and the one register
    logic        chk_en;
    logic [15:0] pkt_len;
    logic [7:0]  vihl;
    logic [15:0] tlen;
    logic [15:0] ff_word;
    logic [7:0]  ttl_q;
    logic [7:0]  proto_q;
    logic [15:0] csum_q;
    logic [15:0] hsum;
    logic [7:0]  even_byte;

    t_result exp_results[$];
    int      pend_cnt = 0;
    int      fail_cnt = 0;

    assign o_pending    = pend_cnt;
    assign o_fail_count = fail_cnt;

    function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    function automatic logic [2:0] classify(input logic [7:0] p);
        case (p)
            PNUM_TCP:  return CLS_TCP;
            PNUM_UDP:  return CLS_UDP;
            PNUM_ICMP: return CLS_ICMP;
            PNUM_IPIP: return CLS_IPIP;
            PNUM_IPV6: return CLS_IPV6;
            default:   return CLS_PAYLOAD;
        endcase
    endfunction

    function automatic void clear_packet_state();
        pkt_len   = '0;
        vihl      = '0;
        tlen      = '0;
        ff_word   = '0;
        ttl_q     = '0;
        proto_q   = '0;
        csum_q    = '0;
        hsum      = '0;
        even_byte = '0;
    endfunction

    // Take one byte; returns 1 with the predicted word when the byte ends a packet
    function automatic bit absorb_byte(input logic [7:0] b, input logic eop,
                                       output t_result res);
        logic [15:0] idx;
        logic [15:0] acc;
        logic [15:0] comp;
        logic [7:0]  v;
        int          hl;
        int          span;
        int          cnt;
        int          tl;
        int          opts;
        int          kept;
        bit          ok;
        res = '0;
        idx = pkt_len;
        // drop bytes once the count has saturated
        if (idx != 16'hFFFF && idx < MAX_PACKET_BYTES_DEF) begin
            pkt_len = idx + 16'd1;
            case (idx)
                OFS_VER_IHL: vihl          = b;
                OFS_TLEN_HI: tlen[15:8]    = b;
                OFS_TLEN_LO: tlen[7:0]     = b;
                OFS_FRAG_HI: ff_word[15:8] = b;
                OFS_FRAG_LO: ff_word[7:0]  = b;
                OFS_TTL:     ttl_q         = b;
                OFS_PROTO:   proto_q       = b;
                OFS_CSUM_HI: csum_q[15:8]  = b;
                OFS_CSUM_LO: csum_q[7:0]   = b;
                default: ;
            endcase
            hl   = vihl[3:0] * 4;
            span = (hl < HDR_MIN) ? HDR_MIN : hl;
            if (idx < span) begin
                v = (idx == OFS_CSUM_HI || idx == OFS_CSUM_LO) ? 8'h00 : b;
                if (!idx[0]) begin
                    even_byte = v;
                end else begin
                    hsum = fold_add(hsum, {even_byte, v});
                end
            end
        end
        if (!eop) begin
            return 1'b0;
        end

        cnt  = pkt_len;
        hl   = vihl[3:0] * 4;
        span = (hl < HDR_MIN) ? HDR_MIN : hl;
        tl   = tlen;
        acc  = hsum;
        // pad a dangling high byte inside the summed span
        if (cnt % 2 == 1 && cnt - 1 < span) begin
            acc = fold_add(acc, {even_byte, 8'h00});
        end
        comp = ~acc;
        ok   = (cnt >= HDR_MIN) && (hl >= HDR_MIN) && (hl <= tl);
        opts = (ok && cnt >= hl) ? hl - HDR_MIN : 0;
        kept = (ok && cnt > tl) ? tl : cnt;

        res.checksum_good = chk_en ? (comp == csum_q) : 1'b1;
        res.header_ok     = ok;
        res.version       = vihl[7:4];
        res.header_bytes  = hl[5:0];
        res.options_bytes = opts[5:0];
        res.total_length  = tlen;
        res.kept_size     = kept[15:0];
        res.protocol      = proto_q;
        res.next_class    = ok ? classify(proto_q) : CLS_NONE;
        res.ttl           = ttl_q;
        res.flags         = ff_word[15:13];
        res.frag_offset   = ff_word[12:0];
        clear_packet_state();
        return 1'b1;
    endfunction

    function automatic void check_field(input string fname, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, fname, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        t_result pred;
        if (!i_rst_n) begin
            chk_en = 1'b1;
            clear_packet_state();
            exp_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                got = t_result'(i_res_word);
                if (exp_results.size() == 0) begin
                    $display("%0t: result word expected none, actual 0x%h", $time, i_res_word);
                    fail_cnt++;
                end else begin
                    want = exp_results.pop_front();
                    check_field("checksum_good", want.checksum_good, got.checksum_good);
                    check_field("header_ok", want.header_ok, got.header_ok);
                    check_field("version", want.version, got.version);
                    check_field("header_bytes", want.header_bytes, got.header_bytes);
                    check_field("options_bytes", want.options_bytes, got.options_bytes);
                    check_field("total_length", want.total_length, got.total_length);
                    check_field("kept_size", want.kept_size, got.kept_size);
                    check_field("protocol", want.protocol, got.protocol);
                    check_field("next_class", want.next_class, got.next_class);
                    check_field("ttl", want.ttl, got.ttl);
                    check_field("flags", want.flags, got.flags);
                    check_field("frag_offset", want.frag_offset, got.frag_offset);
                    check_field("pad", want.pad, got.pad);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                chk_en = i_cfg_data;
            end
            if (i_byte_valid && i_byte_ready) begin
                if (absorb_byte(i_byte, i_byte_last, pred)) begin
                    exp_results.push_back(pred);
                end
            end
        end
        pend_cnt = exp_results.size();
    end

endmodule

FILE: test/tb_ipv4_header_parse_check_unit.sv
// Testbench top for the IPv4 header parse and check unit.
// Drives packets and config writes, holds the result checker beside the block, gives the verdict.
// Depends on ihpc_pkg, ipv4_header_parse_check_unit and ihpc_result_checker.
module tb_ipv4_header_parse_check_unit;
    import ihpc_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int LIMIT_CYCLES = 600000;
    localparam int SETTLE       = 8;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic                 i_cfg_data    = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = 8'h00;
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_O_W-1:0] m_axis_tdata;

    int         pending;
    int         fail_count;
    bit         no_gaps = 1'b0;
    logic [7:0] pkt[$];

    ipv4_header_parse_check_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ihpc_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_byte_valid (s_axis_tvalid),
        .i_byte_ready (s_axis_tready),
        .i_byte       (s_axis_tdata),
        .i_byte_last  (s_axis_tlast),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_word   (m_axis_tdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 17);
    end

    initial begin
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("tb_ipv4_header_parse_check_unit failed");
        $finish;
    end

    // Header checksum over the first hdr_len bytes of pkt, checksum word as zero
    function automatic logic [15:0] hdr_csum(input int hdr_len);
        logic [16:0] acc;
        acc = '0;
        for (int i = 0; i < hdr_len; i += 2) begin
            if (i != OFS_CSUM_HI) begin
                acc = {1'b0, acc[15:0]} + {1'b0, pkt[i], pkt[i + 1]};
                acc = {1'b0, acc[15:0] + {15'd0, acc[16]}};
            end
        end
        return ~acc[15:0];
    endfunction

    function automatic logic [7:0] pick_proto();
        case ($urandom_range(0, 5))
            0:       return PNUM_TCP;
            1:       return PNUM_UDP;
            2:       return PNUM_ICMP;
            3:       return PNUM_IPIP;
            4:       return PNUM_IPV6;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed header with random content; total length and capture may disagree
    task automatic build_ipv4();
        int          ihl;
        int          hb;
        int          total;
        int          tl;
        int          r;
        int          cut;
        logic [3:0]  ver;
        logic [15:0] cs;
        ihl   = $urandom_range(5, 15);
        hb    = ihl * 4;
        total = hb + $urandom_range(0, 24);
        r     = $urandom_range(0, 99);
        if (r < 60) begin
            tl = total;
        end else if (r < 75) begin
            tl = total + $urandom_range(1, 40);
        end else begin
            tl = $urandom_range(0, total);
        end
        pkt.delete();
        for (int i = 0; i < total; i++) begin
            pkt.push_back(8'($urandom_range(0, 255)));
        end
        ver = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'd4;
        pkt[OFS_VER_IHL] = {ver, ihl[3:0]};
        pkt[OFS_TLEN_HI] = tl[15:8];
        pkt[OFS_TLEN_LO] = tl[7:0];
        pkt[OFS_PROTO]   = pick_proto();
        cs = hdr_csum(hb);
        if ($urandom_range(0, 99) < 85) begin
            pkt[OFS_CSUM_HI] = cs[15:8];
            pkt[OFS_CSUM_LO] = cs[7:0];
        end
        // cut the capture short now and then, options included
        if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, total);
            while (pkt.size() > cut) begin
                void'(pkt.pop_back());
            end
        end
    endtask

    // Random bytes, often with a header length below the minimum
    task automatic build_noise();
        int len;
        len = $urandom_range(1, 70);
        pkt.delete();
        for (int i = 0; i < len; i++) begin
            pkt.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 1) == 1) begin
            pkt[OFS_VER_IHL] = {4'd4, 4'($urandom_range(0, 4))};
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!no_gaps && $urandom_range(0, 99) < 17) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt.size(); i++) begin
            send_byte(pkt[i], i == pkt.size() - 1);
        end
    endtask

    // Hold the sender until every expected word is out and the pipe is empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_check_enable(input logic en);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= en;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_random(input int n);
        int sent;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 99) < 75) begin
                build_ipv4();
            end else begin
                build_noise();
            end
            sent += pkt.size();
            send_packet();
        end
    endtask

    initial begin : stimulus
        logic [15:0] cs;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one-byte packet, then a short odd one
        pkt = '{8'hFF};
        send_packet();
        pkt = '{8'h00, 8'h55, 8'hAA};
        send_packet();
        // minimal header, checksum good, checking at its reset value
        pkt = '{8'h45, 8'h00, 8'h00, 8'h14, 8'h12, 8'h34, 8'h40, 8'h00, 8'h40, PNUM_TCP,
                8'h00, 8'h00, 8'hC0, 8'hA8, 8'h00, 8'h01, 8'h0A, 8'h00, 8'h00, 8'hFF};
        cs = hdr_csum(20);
        pkt[OFS_CSUM_HI] = cs[15:8];
        pkt[OFS_CSUM_LO] = cs[7:0];
        send_packet();

        write_check_enable(1'b0);
        run_random(600);
        write_check_enable(1'b1);
        no_gaps = 1'b1;
        run_random(500);
        no_gaps = 1'b0;
        write_check_enable(1'b0);
        run_random(300);
        write_check_enable(1'b1);
        run_random(300);

        drain();
        if (fail_count == 0) begin
            $display("tb_ipv4_header_parse_check_unit passed");
        end else begin
            $display("tb_ipv4_header_parse_check_unit failed");
        end
        $finish;
    end

endmodule
